/* rtl/core/smp_pkg.sv */
// shared types and constants for the sha message padder
// no dependencies; imported by every module of the padder
package smp_pkg;

  // width of the message byte counter
  localparam int COUNT_BITS = 61;

  // entries in the job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_MARKER   = 8'h80;
  // word index within a 64-byte block that holds the length
  localparam logic [2:0] LEN_WORD_IDX = 3'd7;
  // last word index that may carry zero fill
  localparam logic [2:0] LAST_FILL_IDX = 3'd6;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic {
    JOB_WORD,
    JOB_PAD
  } job_kind_t;

  // one unit of work handed from front to back
  typedef struct packed {
    job_kind_t   kind;
    logic [63:0] word;       // finished data word, or the marker word
    logic        block_end;  // only for data words
    logic [2:0]  word_idx;   // block position of the marker word
    logic [63:0] bit_len;    // message length in bits
  } job_t;

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_ZERO,
    BK_LEN
  } back_state_t;

endpackage

/* rtl/core/smp_front.sv */
// front of the padder: takes bytes, packs words, builds padding jobs
// depends on smp_pkg
module smp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          push,
  output smp_pkg::job_t push_job
);
  import smp_pkg::*;

  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [55:0]           partial_word, partial_word_next;
  logic                  accept;
  logic [63:0]           marker_word;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // partial bytes plus marker, moved up to the top of the word
  assign marker_word = {partial_word, PAD_MARKER} << {~byte_count[2:0], 3'b000};

  always_comb begin
    push              = 1'b0;
    push_job.kind     = JOB_WORD;
    push_job.word     = {partial_word, data_byte};
    push_job.block_end = (byte_count[5:0] == 6'd63);
    push_job.word_idx = byte_count[5:3];
    push_job.bit_len  = 64'(byte_count) << 3;
    byte_count_next   = byte_count;
    partial_word_next = partial_word;
    if (accept) begin
      if (cmd == CMD_DATA) begin
        byte_count_next = byte_count + 1'b1;
        if (byte_count[2:0] == 3'd7) begin
          push              = 1'b1;
          partial_word_next = '0;
        end else begin
          partial_word_next = {partial_word[47:0], data_byte};
        end
      end else begin
        push              = 1'b1;
        push_job.kind     = JOB_PAD;
        push_job.word     = marker_word;
        byte_count_next   = '0;
        partial_word_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      partial_word <= '0;
    end else begin
      byte_count   <= byte_count_next;
      partial_word <= partial_word_next;
    end
  end

endmodule

/* rtl/core/smp_queue.sv */
// short job queue between front and back
// depends on smp_pkg
module smp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output smp_pkg::job_t head
);
  import smp_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push, do_pop;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/smp_back.sv */
// back of the padder: emits data words and runs the padding sequence
// depends on smp_pkg
module smp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  smp_pkg::job_t q_head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_word,
  output logic          block_end,
  output logic          message_end
);
  import smp_pkg::*;

  back_state_t state, state_next;
  logic [2:0]  idx, idx_next;
  logic [63:0] bit_len, bit_len_next;
  logic        out_valid_next;
  logic [63:0] out_word_next;
  logic        block_end_next, message_end_next;
  logic        advance;

  assign advance = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    bit_len_next     = bit_len;
    out_valid_next   = out_valid && !out_ready;
    out_word_next    = out_word;
    block_end_next   = block_end;
    message_end_next = message_end;
    pop              = 1'b0;
    case (state)
      BK_FETCH: begin
        if (advance && q_not_empty) begin
          pop              = 1'b1;
          out_valid_next   = 1'b1;
          out_word_next    = q_head.word;
          message_end_next = 1'b0;
          if (q_head.kind == JOB_WORD) begin
            block_end_next = q_head.block_end;
          end else begin
            block_end_next = (q_head.word_idx == LEN_WORD_IDX);
            idx_next       = 3'(q_head.word_idx + 3'd1);
            bit_len_next   = q_head.bit_len;
            state_next     = (q_head.word_idx == LAST_FILL_IDX) ? BK_LEN : BK_ZERO;
          end
        end
      end
      BK_ZERO: begin
        if (advance) begin
          out_valid_next   = 1'b1;
          out_word_next    = '0;
          block_end_next   = 1'b0;
          message_end_next = 1'b0;
          if (idx == LAST_FILL_IDX) begin
            state_next = BK_LEN;
          end else begin
            idx_next = 3'(idx + 3'd1);
          end
        end
      end
      BK_LEN: begin
        if (advance) begin
          out_valid_next   = 1'b1;
          out_word_next    = bit_len;
          block_end_next   = 1'b1;
          message_end_next = 1'b1;
          state_next       = BK_FETCH;
        end
      end
      default: begin
        state_next = BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_FETCH;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    bit_len     <= bit_len_next;
    out_word    <= out_word_next;
    block_end   <= block_end_next;
    message_end <= message_end_next;
  end

endmodule

/* rtl/core/sha_message_padder.sv */
// sha message padder top: one byte per accepted transfer in, 64-bit words out
// a data word passes through the queue and then the output register; throughput: one
// byte per cycle unless the queue is full; an end mark yields 2 to 9 words at one per
// cycle while m_tready is high; the front keeps taking new bytes while the back pads
// reset: synchronous active-high rst clears the byte counter, partial word, queue
// and back sequencer; no clearing pass, ready on the first cycle after reset
module sha_message_padder (
  input  logic        clk,
  input  logic        rst,
  // input side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] cmd: 0 data byte, 1 end of message
  // output side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] out_word, first byte in the top bits
  output logic        m_tuser,   // [0] block_end
  output logic        m_tlast    // message_end, set on the length word
);
  import smp_pkg::*;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic q_not_empty;
  job_t q_head;
  logic pop;

  // front packs bytes and turns each finished word or end mark into a job
  smp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .data_byte (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // small queue so the front keeps running while padding is emitted
  smp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back drives the registered output word, zero fill and length
  smp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_word    (m_tdata),
    .block_end   (m_tuser),
    .message_end (m_tlast)
  );

endmodule
